// ----- hdl/cbp_pkg.sv -----
`timescale 1ns / 1ps

package cbp_pkg;

  localparam int X_W     = 10;
  localparam int WID_W   = 11;
  localparam int HGT_W   = 16;
  localparam int RIGHT_W = 12;

  localparam logic FUNC_PLACE = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SPAN = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic               func;
    logic [X_W-1:0]     x;
    logic [WID_W-1:0]   width;
    logic [HGT_W-1:0]   height;
  } in_word_t;

  typedef struct packed {
    logic [HGT_W-1:0]   y_bottom;
    logic [WID_W-1:0]   x_right;
    logic [HGT_W-1:0]   y_top;
    logic [WID_W-1:0]   bound_width;
    logic [HGT_W-1:0]   bound_height;
    status_t            status;
  } out_word_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CLEAR,
    FSM_READ,
    FSM_LAST,
    FSM_TOP,
    FSM_WRITE,
    FSM_DONE
  } fsm_t;

  typedef enum logic [1:0] {
    KIND_PLACE,
    KIND_SPAN,
    KIND_CLEAR
  } kind_t;

endpackage

// ----- hdl/cbp_chan_if.sv -----
`timescale 1ns / 1ps

interface cbp_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/contour_block_placer_core.sv -----
`timescale 1ns / 1ps

// Skyline placer: the contour (one height per column) lives in a single
// memory with one write and one registered read port. A place word reads
// each column of its span one per cycle, then writes the new top back one
// per cycle; a zero-width word skips both sweeps, and a word whose span runs
// past the last column is answered without touching the memory. A clear
// word, and reset, sweep the whole memory one column per cycle, during which
// no word is accepted. One word is in work at a time; a finished result
// waits in the output register while the next word is accepted.
module contour_block_placer_core #(
  parameter int CONTOUR_COLS = 1024,
  parameter int HEIGHT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  cbp_chan_if.sink    in_chan,
  cbp_chan_if.source  out_chan
);

  import cbp_pkg::*;

  localparam int ADDR_W = $clog2(CONTOUR_COLS);
  localparam int CNT_W  = (ADDR_W > RIGHT_W) ? ADDR_W : RIGHT_W;
  localparam int SUM_W  = ((HEIGHT_BITS > HGT_W) ? HEIGHT_BITS : HGT_W) + 1;

  fsm_t                   state_r, state_nxt;
  kind_t                  kind_r;
  logic                   clr_reply_r;
  logic [CNT_W-1:0]       col_r;
  logic [CNT_W-1:0]       last_r;
  logic [CNT_W-1:0]       x_r;
  logic [RIGHT_W-1:0]     right_r;
  logic                   w_zero_r;
  logic [HGT_W-1:0]       h_r;
  logic [HEIGHT_BITS-1:0] bottom_r;
  logic [HEIGHT_BITS-1:0] top_r;
  logic                   sat_r;
  logic                   rd_vld_r;
  logic [RIGHT_W-1:0]     max_right_r;
  logic [HEIGHT_BITS-1:0] max_top_r;
  logic                   out_valid_r;
  out_word_t              out_word_r;

  logic                   in_ready;
  logic                   in_take;
  logic                   out_load;
  logic                   mem_we;
  logic [HEIGHT_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [HEIGHT_BITS-1:0] mem_rdata;
  logic [RIGHT_W-1:0]     right_in;
  logic                   span_bad;
  logic [SUM_W-1:0]       top_sum;
  logic                   top_sat;
  logic [RIGHT_W-1:0]     new_right;
  logic [HEIGHT_BITS-1:0] new_top;

  cbp_contour_mem #(
    .DEPTH  (CONTOUR_COLS),
    .DATA_W (HEIGHT_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (ADDR_W'(col_r)),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (ADDR_W'(col_r)),
    .rd_data (mem_rdata)
  );

  assign right_in = RIGHT_W'(in_chan.data.x) + RIGHT_W'(in_chan.data.width);
  assign span_bad = 32'(right_in) > 32'(CONTOUR_COLS);
  assign in_take  = in_chan.valid && in_ready;

  assign top_sum = SUM_W'(bottom_r) + SUM_W'(h_r);
  assign top_sat = |top_sum[SUM_W-1:HEIGHT_BITS];

  assign new_right = (right_r > max_right_r) ? right_r : max_right_r;
  assign new_top   = (top_r > max_top_r) ? top_r : max_top_r;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = top_r;
    mem_re    = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          if (in_chan.data.func == FUNC_CLEAR) begin
            state_nxt = FSM_CLEAR;
          end else if (span_bad) begin
            state_nxt = FSM_DONE;
          end else if (in_chan.data.width == '0) begin
            state_nxt = FSM_TOP;
          end else begin
            state_nxt = FSM_READ;
          end
        end
      end
      FSM_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (col_r == CNT_W'(CONTOUR_COLS - 1)) begin
          state_nxt = clr_reply_r ? FSM_DONE : FSM_IDLE;
        end
      end
      FSM_READ: begin
        mem_re = 1'b1;
        if (col_r == last_r) begin
          state_nxt = FSM_LAST;
        end
      end
      FSM_LAST: begin
        state_nxt = FSM_TOP;
      end
      FSM_TOP: begin
        state_nxt = w_zero_r ? FSM_DONE : FSM_WRITE;
      end
      FSM_WRITE: begin
        mem_we = 1'b1;
        if (col_r == last_r) begin
          state_nxt = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_CLEAR;
      clr_reply_r <= 1'b0;
      col_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= mem_re;
      if (in_take) begin
        clr_reply_r <= 1'b1;
        col_r       <= (in_chan.data.func == FUNC_CLEAR) ? '0 : CNT_W'(in_chan.data.x);
      end else if (state_r == FSM_TOP) begin
        col_r <= x_r;
      end else if (mem_we || mem_re) begin
        col_r <= col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r      <= CNT_W'(in_chan.data.x);
      right_r  <= right_in;
      last_r   <= CNT_W'(right_in - RIGHT_W'(1));
      w_zero_r <= (in_chan.data.width == '0);
      h_r      <= in_chan.data.height;
      bottom_r <= '0;
      if (in_chan.data.func == FUNC_CLEAR) begin
        kind_r <= KIND_CLEAR;
      end else if (span_bad) begin
        kind_r <= KIND_SPAN;
      end else begin
        kind_r <= KIND_PLACE;
      end
    end else if (rd_vld_r && (mem_rdata > bottom_r)) begin
      bottom_r <= mem_rdata;
    end
    if (state_r == FSM_TOP) begin
      top_r <= top_sat ? '1 : top_sum[HEIGHT_BITS-1:0];
      sat_r <= top_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_right_r <= '0;
      max_top_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (kind_r == KIND_CLEAR) begin
          max_right_r <= '0;
          max_top_r   <= '0;
        end else if (kind_r == KIND_PLACE) begin
          max_right_r <= new_right;
          max_top_r   <= new_top;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      case (kind_r)
        KIND_PLACE: begin
          out_word_r.y_bottom     <= HGT_W'(bottom_r);
          out_word_r.x_right      <= WID_W'(right_r);
          out_word_r.y_top        <= HGT_W'(top_r);
          out_word_r.bound_width  <= WID_W'(new_right);
          out_word_r.bound_height <= HGT_W'(new_top);
          out_word_r.status       <= sat_r ? STAT_SAT : STAT_OK;
        end
        KIND_SPAN: begin
          out_word_r.y_bottom     <= '0;
          out_word_r.x_right      <= '0;
          out_word_r.y_top        <= '0;
          out_word_r.bound_width  <= WID_W'(max_right_r);
          out_word_r.bound_height <= HGT_W'(max_top_r);
          out_word_r.status       <= STAT_SPAN;
        end
        default: begin
          out_word_r.y_bottom     <= '0;
          out_word_r.x_right      <= '0;
          out_word_r.y_top        <= '0;
          out_word_r.bound_width  <= '0;
          out_word_r.bound_height <= '0;
          out_word_r.status       <= STAT_OK;
        end
      endcase
    end
  end

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_word_r;

  // contour is never written while a span is being read
  a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_READ || state_r == FSM_LAST) |-> !mem_we)
    else $error("contour write during span read");

  // read data only arrives right after a read issue
  a_rd_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(state_r) == FSM_READ))
    else $error("read data without a read issue");

  // span write stays within the span
  a_write_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_WRITE) |-> (col_r >= x_r && col_r <= last_r))
    else $error("contour write outside span");

  // a saturated top is the height limit
  a_sat_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && kind_r == KIND_PLACE && sat_r) |-> (top_r == '1))
    else $error("saturated top is not the limit");

endmodule

// ----- hdl/cbp_contour_mem.sv -----
`timescale 1ns / 1ps

module cbp_contour_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
